>>> design/tsfm_pkg.sv
`default_nettype none

package tsfm_pkg;

    localparam int ADC_BITS = 12;

    // samples per burst and trimmed-mean shift
    localparam int BURST_LEN   = 10;
    localparam int MEAN_SHIFT  = 3;
    localparam int POS_BITS    = 4;
    localparam int BURST_BITS  = 2;
    localparam int SUM_BITS    = 16;

    // point acceptance limits
    localparam logic [ADC_BITS-1:0] PAIR_TOLERANCE = 12'd50;
    localparam logic [ADC_BITS-1:0] RAW_MIN        = 12'd100;
    localparam logic [ADC_BITS-1:0] RAW_MAX        = 12'd3900;

    // config geometry
    localparam int GAIN_BITS  = 20;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = ADC_BITS + GAIN_BITS;
    localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS;
    localparam int COORD_BITS = QUOT_BITS + 2;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // burst order within one point
    typedef enum logic [BURST_BITS-1:0] {
        BURST_X0 = 2'd0,
        BURST_Y0 = 2'd1,
        BURST_X1 = 2'd2,
        BURST_Y1 = 2'd3
    } burst_t;

    // register map, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_X_OFFSET      = 3'd2,
        REG_Y_OFFSET      = 3'd3,
        REG_X_GAIN        = 3'd4,
        REG_Y_GAIN        = 3'd5,
        REG_MIRROR_X      = 3'd6
    } reg_index_t;

    localparam logic [ADC_BITS-1:0]  RST_SCREEN_WIDTH  = 12'd240;
    localparam logic [ADC_BITS-1:0]  RST_SCREEN_HEIGHT = 12'd320;
    localparam logic [ADC_BITS-1:0]  RST_OFFSET        = 12'd100;
    localparam logic [GAIN_BITS-1:0] RST_GAIN          = 20'd6554;

endpackage

`default_nettype wire

>>> design/touch_sample_filter_mapper.sv
// out_valid rises once the input transaction that lifts the pen or ends the fourth
// burst has passed the seven register stages, s1 to s6 and the output register;
// samples that end no point give no result transaction; the first stage is loaded
// at acceptance; throughput: one input transaction per cycle while in_stall is low
// burst accumulation (sum, min, max) updates in the cycle of each input transaction
// reset: rst_n is asynchronous and active low; config returns to its defaults,
// the burst counters, pipeline valids and press status are cleared
`default_nettype none

module touch_sample_filter_mapper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        pen_down,
    input  wire logic [11:0] sample,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             touched,
    output logic             first_press,
    output logic [11:0]      pos_x,
    output logic [11:0]      pos_y,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [tsfm_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [tsfm_pkg::DATA_BITS-1:0] pwdata,
    output logic [tsfm_pkg::DATA_BITS-1:0]      prdata,
    output logic             pready
);

    localparam int AB = tsfm_pkg::ADC_BITS;
    localparam int GB = tsfm_pkg::GAIN_BITS;
    localparam int PB = tsfm_pkg::PROD_BITS;
    localparam int CB = tsfm_pkg::COORD_BITS;
    localparam int SB = tsfm_pkg::SUM_BITS;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [AB-1:0] screen_width_reg, screen_height_reg;
    logic [AB-1:0] x_offset_reg, y_offset_reg;
    logic [GB-1:0] x_gain_reg, y_gain_reg;
    logic          mirror_x_reg;
    logic          cfg_write;
    tsfm_pkg::reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = tsfm_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= tsfm_pkg::RST_SCREEN_WIDTH;
            screen_height_reg <= tsfm_pkg::RST_SCREEN_HEIGHT;
            x_offset_reg      <= tsfm_pkg::RST_OFFSET;
            y_offset_reg      <= tsfm_pkg::RST_OFFSET;
            x_gain_reg        <= tsfm_pkg::RST_GAIN;
            y_gain_reg        <= tsfm_pkg::RST_GAIN;
            mirror_x_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tsfm_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[AB-1:0];
                tsfm_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[AB-1:0];
                tsfm_pkg::REG_X_OFFSET:      x_offset_reg      <= pwdata[AB-1:0];
                tsfm_pkg::REG_Y_OFFSET:      y_offset_reg      <= pwdata[AB-1:0];
                tsfm_pkg::REG_X_GAIN:        x_gain_reg        <= pwdata[GB-1:0];
                tsfm_pkg::REG_Y_GAIN:        y_gain_reg        <= pwdata[GB-1:0];
                tsfm_pkg::REG_MIRROR_X:      mirror_x_reg      <= pwdata[0];
                default: ; // unmapped address, write dropped
            endcase
        end
    end

    // read back, unmapped addresses read zero
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            tsfm_pkg::REG_SCREEN_WIDTH:  prdata = {20'd0, screen_width_reg};
            tsfm_pkg::REG_SCREEN_HEIGHT: prdata = {20'd0, screen_height_reg};
            tsfm_pkg::REG_X_OFFSET:      prdata = {20'd0, x_offset_reg};
            tsfm_pkg::REG_Y_OFFSET:      prdata = {20'd0, y_offset_reg};
            tsfm_pkg::REG_X_GAIN:        prdata = {12'd0, x_gain_reg};
            tsfm_pkg::REG_Y_GAIN:        prdata = {12'd0, y_gain_reg};
            tsfm_pkg::REG_MIRROR_X:      prdata = {31'd0, mirror_x_reg};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake: a stage moves when the next one is empty or moving
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, out_valid_reg;
    logic rdy_out, rdy6, rdy5, rdy4, rdy3, rdy2, rdy1;
    logic in_accept;

    assign rdy_out = !out_valid_reg || !out_stall;
    assign rdy6    = !s6_valid_reg || rdy_out;
    assign rdy5    = !s5_valid_reg || rdy6;
    assign rdy4    = !s4_valid_reg || rdy5;
    assign rdy3    = !s3_valid_reg || rdy4;
    assign rdy2    = !s2_valid_reg || rdy3;
    assign rdy1    = !s1_valid_reg || rdy2;

    assign in_stall  = !rdy1;
    assign in_accept = in_valid && rdy1;

    // ------------------------------------------------------------------
    // stage 0: burst accumulation at the input transaction
    // ------------------------------------------------------------------
    logic [tsfm_pkg::POS_BITS-1:0] pos_reg;
    tsfm_pkg::burst_t              burst_reg;
    logic [SB-1:0]                 sum_reg, sum_next;
    logic [AB-1:0]                 min_reg, min_next, max_reg, max_next;
    logic                          burst_end;

    assign burst_end = (pos_reg == tsfm_pkg::POS_BITS'(tsfm_pkg::BURST_LEN - 1));

    always_comb
    begin
        if (pos_reg == '0)
        begin
            sum_next = SB'(sample);
            min_next = sample;
            max_next = sample;
        end
        else
        begin
            sum_next = sum_reg + SB'(sample);
            min_next = (sample < min_reg) ? sample : min_reg;
            max_next = (sample > max_reg) ? sample : max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            burst_reg <= tsfm_pkg::BURST_X0;
            sum_reg   <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
        end
        else if (in_accept)
        begin
            if (!pen_down)
            begin
                // pen up aborts the point
                pos_reg   <= '0;
                burst_reg <= tsfm_pkg::BURST_X0;
                sum_reg   <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                min_reg <= min_next;
                max_reg <= max_next;
                if (burst_end)
                begin
                    pos_reg   <= '0;
                    burst_reg <= tsfm_pkg::burst_t'(burst_reg + 2'd1);
                end
                else
                begin
                    pos_reg <= pos_reg + tsfm_pkg::POS_BITS'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: burst totals (or a release) waiting for the trimmed mean
    // ------------------------------------------------------------------
    logic             s1_pen_reg;
    tsfm_pkg::burst_t s1_burst_reg;
    logic [SB-1:0]    s1_sum_reg;
    logic [AB-1:0]    s1_min_reg, s1_max_reg;
    logic [SB-1:0]    s1_trim;
    logic [AB-1:0]    s1_mean;
    logic             s1_adv, s1_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rdy1)
            s1_valid_reg <= in_accept && (!pen_down || burst_end);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_pen_reg   <= pen_down;
            s1_burst_reg <= burst_reg;
            s1_sum_reg   <= sum_next;
            s1_min_reg   <= min_next;
            s1_max_reg   <= max_next;
        end
    end

    assign s1_trim = s1_sum_reg - SB'(s1_min_reg) - SB'(s1_max_reg);
    assign s1_mean = s1_trim[tsfm_pkg::MEAN_SHIFT +: AB];
    assign s1_adv  = s1_valid_reg && rdy2;
    assign s1_last = !s1_pen_reg || (s1_burst_reg == tsfm_pkg::BURST_Y1);

    // means of the first three bursts are kept until the fourth completes
    logic [AB-1:0] first_x_mean_reg, first_y_mean_reg, second_x_mean_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_mean_reg  <= '0;
            first_y_mean_reg  <= '0;
            second_x_mean_reg <= '0;
        end
        else if (s1_adv && s1_pen_reg)
        begin
            case (s1_burst_reg)
                tsfm_pkg::BURST_X0: first_x_mean_reg  <= s1_mean;
                tsfm_pkg::BURST_Y0: first_y_mean_reg  <= s1_mean;
                tsfm_pkg::BURST_X1: second_x_mean_reg <= s1_mean;
                default: ; // fourth burst goes down the pipeline
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 2: pair check and pair average
    // ------------------------------------------------------------------
    logic          s2_pen_reg;
    logic [AB-1:0] s2_mean_reg;
    logic [AB-1:0] dx_ab, dx_ba, dy_ab, dy_ba, diff_x, diff_y;
    logic [AB:0]   sum_x, sum_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= s1_valid_reg && s1_last;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_pen_reg  <= s1_pen_reg;
            s2_mean_reg <= s1_mean;
        end
    end

    assign dx_ab  = first_x_mean_reg - second_x_mean_reg;
    assign dx_ba  = second_x_mean_reg - first_x_mean_reg;
    assign dy_ab  = first_y_mean_reg - s2_mean_reg;
    assign dy_ba  = s2_mean_reg - first_y_mean_reg;
    assign diff_x = (first_x_mean_reg > second_x_mean_reg) ? dx_ab : dx_ba;
    assign diff_y = (first_y_mean_reg > s2_mean_reg) ? dy_ab : dy_ba;
    assign sum_x  = {1'b0, first_x_mean_reg} + {1'b0, second_x_mean_reg};
    assign sum_y  = {1'b0, first_y_mean_reg} + {1'b0, s2_mean_reg};

    // ------------------------------------------------------------------
    // stage 3: range check, press status, offset
    // ------------------------------------------------------------------
    logic          s3_pen_reg, s3_pair_ok_reg;
    logic [AB-1:0] s3_ax_reg, s3_ay_reg;
    logic          s3_ok, s3_adv;
    logic [AB:0]   s3_dx, s3_dy;
    logic          pressed_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (rdy3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_pen_reg     <= s2_pen_reg;
            s3_pair_ok_reg <= (diff_x <= tsfm_pkg::PAIR_TOLERANCE)
                              && (diff_y <= tsfm_pkg::PAIR_TOLERANCE);
            s3_ax_reg      <= sum_x[AB:1];
            s3_ay_reg      <= sum_y[AB:1];
        end
    end

    assign s3_ok  = s3_pen_reg && s3_pair_ok_reg
                    && (s3_ax_reg >= tsfm_pkg::RAW_MIN) && (s3_ax_reg <= tsfm_pkg::RAW_MAX)
                    && (s3_ay_reg >= tsfm_pkg::RAW_MIN) && (s3_ay_reg <= tsfm_pkg::RAW_MAX);
    assign s3_adv = s3_valid_reg && rdy4;
    assign s3_dx  = {1'b0, s3_ax_reg} - {1'b0, x_offset_reg};
    assign s3_dy  = {1'b0, s3_ay_reg} - {1'b0, y_offset_reg};

    // release and rejection both clear the press, a good point sets it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pressed_flag_reg <= 1'b0;
        else if (s3_adv)
            pressed_flag_reg <= s3_ok;
    end

    // ------------------------------------------------------------------
    // stage 4: sign and magnitude into the gain multipliers
    // ------------------------------------------------------------------
    logic          s4_ok_reg, s4_first_reg, s4_x_neg_reg, s4_y_neg_reg;
    logic [AB-1:0] s4_x_mag_reg, s4_y_mag_reg;
    logic [AB:0]   s3_dx_neg, s3_dy_neg;

    assign s3_dx_neg = -s3_dx;
    assign s3_dy_neg = -s3_dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (rdy4)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_ok_reg    <= s3_ok;
            s4_first_reg <= !pressed_flag_reg;
            s4_x_neg_reg <= s3_dx[AB];
            s4_y_neg_reg <= s3_dy[AB];
            s4_x_mag_reg <= s3_dx[AB] ? s3_dx_neg[AB-1:0] : s3_dx[AB-1:0];
            s4_y_mag_reg <= s3_dy[AB] ? s3_dy_neg[AB-1:0] : s3_dy[AB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: gain products
    // ------------------------------------------------------------------
    logic          s5_ok_reg, s5_first_reg, s5_x_neg_reg, s5_y_neg_reg;
    logic [PB-1:0] s5_x_prod_reg, s5_y_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (rdy5)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_ok_reg     <= s4_ok_reg;
            s5_first_reg  <= s4_first_reg;
            s5_x_neg_reg  <= s4_x_neg_reg;
            s5_y_neg_reg  <= s4_y_neg_reg;
            s5_x_prod_reg <= PB'(s4_x_mag_reg) * PB'(x_gain_reg);
            s5_y_prod_reg <= PB'(s4_y_mag_reg) * PB'(y_gain_reg);
        end
    end

    // ------------------------------------------------------------------
    // stage 6: drop fraction toward zero, restore sign, mirror
    // ------------------------------------------------------------------
    logic                 s6_ok_reg, s6_first_reg;
    logic signed [CB-1:0] s6_sx_reg, s6_sy_reg;
    logic signed [CB-1:0] qx, qy, sx_signed, sy_signed, sx_mirror;

    assign qx        = signed'(CB'(s5_x_prod_reg[PB-1:tsfm_pkg::FRAC_BITS]));
    assign qy        = signed'(CB'(s5_y_prod_reg[PB-1:tsfm_pkg::FRAC_BITS]));
    assign sx_signed = s5_x_neg_reg ? -qx : qx;
    assign sy_signed = s5_y_neg_reg ? -qy : qy;
    assign sx_mirror = signed'(CB'(screen_width_reg)) - sx_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (rdy6)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            s6_ok_reg    <= s5_ok_reg;
            s6_first_reg <= s5_first_reg;
            s6_sx_reg    <= mirror_x_reg ? sx_mirror : sx_signed;
            s6_sy_reg    <= sy_signed;
        end
    end

    // ------------------------------------------------------------------
    // output register: clamp to the screen
    // ------------------------------------------------------------------
    logic          touched_reg, first_press_reg;
    logic [AB-1:0] pos_x_reg, pos_y_reg;
    logic [AB-1:0] clamp_x, clamp_y;

    always_comb
    begin
        if (screen_width_reg == '0 || s6_sx_reg[CB-1])
            clamp_x = '0;
        else if (s6_sx_reg >= signed'(CB'(screen_width_reg)))
            clamp_x = screen_width_reg - AB'(1);
        else
            clamp_x = s6_sx_reg[AB-1:0];

        if (screen_height_reg == '0 || s6_sy_reg[CB-1])
            clamp_y = '0;
        else if (s6_sy_reg >= signed'(CB'(screen_height_reg)))
            clamp_y = screen_height_reg - AB'(1);
        else
            clamp_y = s6_sy_reg[AB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy_out)
            out_valid_reg <= s6_valid_reg;
    end

    // release or rejected point gives an all-zero transaction
    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            touched_reg     <= s6_ok_reg;
            first_press_reg <= s6_ok_reg && s6_first_reg;
            pos_x_reg       <= s6_ok_reg ? clamp_x : '0;
            pos_y_reg       <= s6_ok_reg ? clamp_y : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign touched     = touched_reg;
    assign first_press = first_press_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;

endmodule

`default_nettype wire
